/* rtl/core/ssd_pkg.sv */
`timescale 1ns / 1ps
package ssd_pkg;

  // Coordinate and difference widths
  localparam int CW    = 32;
  localparam int DW    = CW + 1;
  // Single products and dot products
  localparam int PRW   = 2 * DW;
  localparam int DOTW  = PRW + 2;
  localparam int MPW   = 2 * DOTW;
  // Wide signed values: determinant, numerators, denominators
  localparam int WIDE  = MPW + 4;
  // Segment parameters s and t, unsigned in [0, 2^TFRAC]
  localparam int TFRAC = 32;
  localparam int QW    = TFRAC + 1;
  localparam int UPW   = DW + QW + 1;
  // Connecting vector component and its square
  localparam int CPW   = UPW + 2;
  localparam int SQW   = 2 * CPW;
  // Square root operand and result
  localparam int OUTW  = 34;
  localparam int XW    = 2 * OUTW;

  // Unit latencies
  localparam int MUL_LAT  = 5;
  localparam int DIV_LAT  = TFRAC + 1;
  localparam int SQRT_LAT = XW / 2;

  typedef logic signed [DW-1:0] coord_t;
  typedef coord_t [2:0] vec_t;

  typedef struct packed {
    vec_t u;
    vec_t v;
    vec_t w;
  } geo_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] d;
    logic signed [DOTW-1:0] e;
  } dots_t;

endpackage

/* rtl/core/ssd_mul.sv */
`timescale 1ns / 1ps
// Pipelined signed multiplier: sign/magnitude, 24-bit limb products,
// row sums, total, sign fix. Five register stages.
module ssd_mul #(
  parameter int W = 68
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int LB  = 24;
  localparam int NL  = (W + LB - 1) / LB;
  localparam int PW  = NL * LB;
  localparam int RWD = 2 * LB + LB * (NL - 1) + 2;

  logic [W-1:0]      am, bm;
  logic              neg1, neg2, neg3, neg4;
  logic [2*LB-1:0]   pp [NL][NL];
  logic [RWD-1:0]    row [NL];
  logic [RWD-1:0]    row_next [NL];
  logic [2*W-1:0]    tot;
  logic [2*W-1:0]    tot_next;
  logic [PW-1:0]     ax, bx;

  assign ax = PW'(am);
  assign bx = PW'(bm);

  // Magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      am   <= a[W-1] ? W'(-a) : W'(a);
      bm   <= b[W-1] ? W'(-b) : W'(b);
      neg1 <= a[W-1] ^ b[W-1];
    end
  end

  // Limb products
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pp[i][j] <= ax[i*LB +: LB] * bx[j*LB +: LB];
        end
      end
    end
  end

  // Row sums
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_next[i] = row_next[i] + (RWD'(pp[i][j]) << (j * LB));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg3 <= neg2;
      for (int i = 0; i < NL; i++) row[i] <= row_next[i];
    end
  end

  // Total
  always_comb begin
    tot_next = '0;
    for (int i = 0; i < NL; i++) begin
      tot_next = tot_next + ((2*W)'(row[i]) << (i * LB));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg4 <= neg3;
      tot  <= tot_next;
    end
  end

  // Sign fix
  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg4 ? $signed(-tot) : $signed(tot);
    end
  end

endmodule

/* rtl/core/ssd_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: floor(num * 2^QB / den), clamped to [0, 2^QB].
// One setup stage, then one quotient bit per stage.
module ssd_div #(
  parameter int W  = 140,
  parameter int QB = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic [QB:0]         q
);

  logic [W-1:0]  r    [QB+1];
  logic [W-1:0]  dv   [QB+1];
  logic [QB-1:0] qa   [QB+1];
  logic          zero [QB+1];
  logic          one  [QB+1];

  // Setup: special cases
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (num <= 0) || (den <= 0);
      one[0]  <= num >= den;
      r[0]    <= W'(num);
      dv[0]   <= W'(den);
      qa[0]   <= '0;
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [W-1:0] rr;
    assign rr = {r[k-1][W-2:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        zero[k] <= zero[k-1];
        one[k]  <= one[k-1];
        dv[k]   <= dv[k-1];
        if (rr >= dv[k-1]) begin
          r[k]  <= rr - dv[k-1];
          qa[k] <= {qa[k-1][QB-2:0], 1'b1};
        end else begin
          r[k]  <= rr;
          qa[k] <= {qa[k-1][QB-2:0], 1'b0};
        end
      end
    end
  end

  assign q = zero[QB] ? '0 : (one[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, qa[QB]});

endmodule

/* rtl/core/ssd_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage (floor).
module ssd_sqrt #(
  parameter int XW = 68
) (
  input  logic              clk,
  input  logic              en,
  input  logic [XW-1:0]     x,
  output logic [XW/2-1:0]   root
);

  localparam int NS = XW / 2;
  localparam int RW = NS + 4;

  logic [XW-1:0] xs [NS];
  logic [RW-1:0] rem [NS];
  logic [NS-1:0] rt [NS];

  for (genvar k = 0; k < NS; k++) begin : g_bit
    logic [XW-1:0] xi;
    logic [RW-1:0] ri;
    logic [NS-1:0] ti;
    logic [RW-1:0] rsh;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign xi = x;
      assign ri = '0;
      assign ti = '0;
    end else begin : g_next
      assign xi = xs[k-1];
      assign ri = rem[k-1];
      assign ti = rt[k-1];
    end

    assign rsh   = {ri[RW-3:0], xi[XW-1:XW-2]};
    assign trial = RW'({ti, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= {xi[XW-3:0], 2'b00};
        if (rsh >= trial) begin
          rem[k] <= rsh - trial;
          rt[k]  <= {ti[NS-2:0], 1'b1};
        end else begin
          rem[k] <= rsh;
          rt[k]  <= {ti[NS-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[NS-1];

endmodule

/* rtl/core/segment_segment_distance_3d.sv */
`timescale 1ns / 1ps
// Channel | signals                                     | item
// --------+---------------------------------------------+---------------------------
// in      | in_valid, in_ready, first_*/second_* x,y,z  | two segments, Q16.16
// out     | out_valid, out_ready, distance              | shortest distance, Q18.16
//
// Pipelined, one item per cycle when not stalled: dot products, 136-bit
// products, clamps, two 33-stage dividers, connecting vector, 34-stage sqrt.
// Synchronous active-high reset clears only the stage valid bits.
// The whole pipeline advances unless the last stage holds an item not taken;
// a stall freezes every stage, so nothing is lost or repeated.
module segment_segment_distance_3d (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         first_start_x,
  input  logic signed [31:0]         first_start_y,
  input  logic signed [31:0]         first_start_z,
  input  logic signed [31:0]         first_end_x,
  input  logic signed [31:0]         first_end_y,
  input  logic signed [31:0]         first_end_z,
  input  logic signed [31:0]         second_start_x,
  input  logic signed [31:0]         second_start_y,
  input  logic signed [31:0]         second_start_z,
  input  logic signed [31:0]         second_end_x,
  input  logic signed [31:0]         second_end_y,
  input  logic signed [31:0]         second_end_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ssd_pkg::OUTW-1:0]   distance
);

  localparam int ST_MUL = 3 + ssd_pkg::MUL_LAT;
  localparam int ST_DIV = ST_MUL + 3;
  localparam int ST_Q   = ST_DIV + ssd_pkg::DIV_LAT;
  localparam int ST_SQ  = ST_Q + 2 + ssd_pkg::MUL_LAT;
  localparam int ST_X   = ST_SQ + 1;
  localparam int LAT    = ST_X + ssd_pkg::SQRT_LAT;
  localparam int W      = ssd_pkg::WIDE;

  logic           adv;
  logic [LAT:1]   vld;

  ssd_pkg::geo_t  geo_pipe [1:ST_Q+1];
  ssd_pkg::geo_t  g1_next;
  ssd_pkg::dots_t dot_pipe [3:ST_DIV-1];
  ssd_pkg::dots_t dots_next;

  logic signed [ssd_pkg::CW-1:0]   p0 [3], p1 [3], q0 [3], q1 [3];
  logic signed [ssd_pkg::PRW-1:0]  pr [5][3];
  logic signed [ssd_pkg::MPW-1:0]  ac, bb, be, cd, ae, bd;
  logic signed [W-1:0]             dd9, sn9, tn9;
  logic signed [W-1:0]             sn10, sd10, tn10, td10;
  logic signed [W-1:0]             sn10_next, sd10_next, tn10_next, td10_next;
  logic signed [W-1:0]             sn11, sd11, tn11, td11;
  logic signed [W-1:0]             sn11_next, sd11_next, tn11_next, td11_next;
  logic signed [W-1:0]             nd, ndb, a10;
  logic [ssd_pkg::QW-1:0]          sc, tc;
  logic signed [ssd_pkg::UPW-1:0]  us [3], vt [3];
  logic signed [ssd_pkg::CPW-1:0]  comp [3];
  logic signed [ssd_pkg::SQW-1:0]  sq [3];
  logic [W-1:0]                    sum_sq;
  logic [ssd_pkg::XW-1:0]          xin;

  // Handshake and valid bits
  assign adv       = !vld[LAT] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // Stage 1: edge and offset vectors
  assign p0 = '{first_start_x, first_start_y, first_start_z};
  assign p1 = '{first_end_x, first_end_y, first_end_z};
  assign q0 = '{second_start_x, second_start_y, second_start_z};
  assign q1 = '{second_end_x, second_end_y, second_end_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g1_next.u[i] = ssd_pkg::DW'(p1[i]) - ssd_pkg::DW'(p0[i]);
      g1_next.v[i] = ssd_pkg::DW'(q1[i]) - ssd_pkg::DW'(q0[i]);
      g1_next.w[i] = ssd_pkg::DW'(p0[i]) - ssd_pkg::DW'(q0[i]);
    end
  end

  // Geometry travels alongside until the connecting vector is built
  always_ff @(posedge clk) begin
    if (adv) begin
      geo_pipe[1] <= g1_next;
      for (int k = 2; k <= ST_Q + 1; k++) geo_pipe[k] <= geo_pipe[k-1];
    end
  end

  // Stage 2: single products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pr[0][i] <= $signed(geo_pipe[1].u[i]) * $signed(geo_pipe[1].u[i]);
        pr[1][i] <= $signed(geo_pipe[1].u[i]) * $signed(geo_pipe[1].v[i]);
        pr[2][i] <= $signed(geo_pipe[1].v[i]) * $signed(geo_pipe[1].v[i]);
        pr[3][i] <= $signed(geo_pipe[1].u[i]) * $signed(geo_pipe[1].w[i]);
        pr[4][i] <= $signed(geo_pipe[1].v[i]) * $signed(geo_pipe[1].w[i]);
      end
    end
  end

  // Stage 3: dot products
  always_comb begin
    dots_next.a = ssd_pkg::DOTW'(pr[0][0]) + ssd_pkg::DOTW'(pr[0][1])
                + ssd_pkg::DOTW'(pr[0][2]);
    dots_next.b = ssd_pkg::DOTW'(pr[1][0]) + ssd_pkg::DOTW'(pr[1][1])
                + ssd_pkg::DOTW'(pr[1][2]);
    dots_next.c = ssd_pkg::DOTW'(pr[2][0]) + ssd_pkg::DOTW'(pr[2][1])
                + ssd_pkg::DOTW'(pr[2][2]);
    dots_next.d = ssd_pkg::DOTW'(pr[3][0]) + ssd_pkg::DOTW'(pr[3][1])
                + ssd_pkg::DOTW'(pr[3][2]);
    dots_next.e = ssd_pkg::DOTW'(pr[4][0]) + ssd_pkg::DOTW'(pr[4][1])
                + ssd_pkg::DOTW'(pr[4][2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_pipe[3] <= dots_next;
      for (int k = 4; k < ST_DIV; k++) dot_pipe[k] <= dot_pipe[k-1];
    end
  end

  // Wide products of dot products
  ssd_mul #(.W(ssd_pkg::DOTW)) u_mul_ac (
    .clk(clk), .en(adv), .a(dot_pipe[3].a), .b(dot_pipe[3].c), .p(ac));
  ssd_mul #(.W(ssd_pkg::DOTW)) u_mul_bb (
    .clk(clk), .en(adv), .a(dot_pipe[3].b), .b(dot_pipe[3].b), .p(bb));
  ssd_mul #(.W(ssd_pkg::DOTW)) u_mul_be (
    .clk(clk), .en(adv), .a(dot_pipe[3].b), .b(dot_pipe[3].e), .p(be));
  ssd_mul #(.W(ssd_pkg::DOTW)) u_mul_cd (
    .clk(clk), .en(adv), .a(dot_pipe[3].c), .b(dot_pipe[3].d), .p(cd));
  ssd_mul #(.W(ssd_pkg::DOTW)) u_mul_ae (
    .clk(clk), .en(adv), .a(dot_pipe[3].a), .b(dot_pipe[3].e), .p(ae));
  ssd_mul #(.W(ssd_pkg::DOTW)) u_mul_bd (
    .clk(clk), .en(adv), .a(dot_pipe[3].b), .b(dot_pipe[3].d), .p(bd));

  // Determinant and raw numerators
  always_ff @(posedge clk) begin
    if (adv) begin
      dd9 <= W'(ac) - W'(bb);
      sn9 <= W'(be) - W'(cd);
      tn9 <= W'(ae) - W'(bd);
    end
  end

  // First clamp: parallel case and s outside [0,1]
  always_comb begin
    sd10_next = dd9;
    td10_next = dd9;
    sn10_next = sn9;
    tn10_next = tn9;
    if (dd9 <= 0) begin
      sn10_next = '0;
      sd10_next = W'(1);
      tn10_next = W'(dot_pipe[ST_MUL+1].e);
      td10_next = W'(dot_pipe[ST_MUL+1].c);
    end else if (sn9 < 0) begin
      sn10_next = '0;
      tn10_next = W'(dot_pipe[ST_MUL+1].e);
      td10_next = W'(dot_pipe[ST_MUL+1].c);
    end else if (sn9 > dd9) begin
      sn10_next = dd9;
      tn10_next = W'(dot_pipe[ST_MUL+1].e) + W'(dot_pipe[ST_MUL+1].b);
      td10_next = W'(dot_pipe[ST_MUL+1].c);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn10 <= sn10_next;
      sd10 <= sd10_next;
      tn10 <= tn10_next;
      td10 <= td10_next;
    end
  end

  // Second clamp: t outside [0,1], s recomputed
  assign nd  = -W'(dot_pipe[ST_MUL+2].d);
  assign ndb = nd + W'(dot_pipe[ST_MUL+2].b);
  assign a10 = W'(dot_pipe[ST_MUL+2].a);

  always_comb begin
    sn11_next = sn10;
    sd11_next = sd10;
    tn11_next = tn10;
    td11_next = td10;
    if (tn10 < 0) begin
      tn11_next = '0;
      if (nd < 0) begin
        sn11_next = '0;
      end else if (nd > a10) begin
        sn11_next = sd10;
      end else begin
        sn11_next = nd;
        sd11_next = a10;
      end
    end else if (tn10 > td10) begin
      tn11_next = td10;
      if (ndb < 0) begin
        sn11_next = '0;
      end else if (ndb > a10) begin
        sn11_next = sd10;
      end else begin
        sn11_next = ndb;
        sd11_next = a10;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn11 <= sn11_next;
      sd11 <= sd11_next;
      tn11 <= tn11_next;
      td11 <= td11_next;
    end
  end

  // Segment parameters
  ssd_div #(.W(W), .QB(ssd_pkg::TFRAC)) u_div_s (
    .clk(clk), .en(adv), .num(sn11), .den(sd11), .q(sc));
  ssd_div #(.W(W), .QB(ssd_pkg::TFRAC)) u_div_t (
    .clk(clk), .en(adv), .num(tn11), .den(td11), .q(tc));

  // Scaled edge vectors
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        us[i] <= $signed(geo_pipe[ST_Q].u[i]) * $signed({1'b0, sc});
        vt[i] <= $signed(geo_pipe[ST_Q].v[i]) * $signed({1'b0, tc});
      end
    end
  end

  // Connecting vector, scaled by 2^TFRAC
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        comp[i] <= (ssd_pkg::CPW'($signed(geo_pipe[ST_Q+1].w[i])) <<< ssd_pkg::TFRAC)
                 + ssd_pkg::CPW'(us[i]) - ssd_pkg::CPW'(vt[i]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    ssd_mul #(.W(ssd_pkg::CPW)) u_mul_sq (
      .clk(clk), .en(adv), .a(comp[i]), .b(comp[i]), .p(sq[i]));
  end

  // Squared length, unscaled; saturates the root at all ones
  assign sum_sq = W'(unsigned'(sq[0])) + W'(unsigned'(sq[1])) + W'(unsigned'(sq[2]));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (|sum_sq[W-1:2*ssd_pkg::TFRAC+ssd_pkg::XW]) begin
        xin <= '1;
      end else begin
        xin <= sum_sq[2*ssd_pkg::TFRAC +: ssd_pkg::XW];
      end
    end
  end

  ssd_sqrt #(.XW(ssd_pkg::XW)) u_sqrt (
    .clk(clk), .en(adv), .x(xin), .root(distance));

endmodule
